// ===== hw/rtl/sint_pkg.sv =====
// Package for the segment intersection unit: coordinate width, derived
// datapath widths and the job record passed from the front end to the back end.
// No dependencies.
package sint_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * DIFF_W;
    localparam int NUM_W       = PROD_W + 1;
    localparam int NX_W        = NUM_W + DIFF_W + 1;
    localparam int QUO_W       = COORD_WIDTH + 1;
    localparam int IN_BITS     = 8 * COORD_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 1 + 2 * COORD_WIDTH;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    // Classified request: sign-normalized den and t numerator plus the
    // segment one terms needed to build the crossing point.
    typedef struct packed {
        logic                          hit;
        logic signed [NUM_W-1:0]       den;
        logic signed [NUM_W-1:0]       tn;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [DIFF_W-1:0]      d1x;
        logic signed [DIFF_W-1:0]      d1y;
    } sint_job_t;

endpackage

// ===== hw/rtl/segment_intersection_unit.sv =====
// Top level of the segment intersection unit: stream ports, front end,
// request queue and back end. Depends on sint_pkg, sint_front, sint_fifo, sint_back.
//
// Each request carries two 2D segments as eight signed 16-bit coordinates and
// yields one result: a hit flag and the crossing point, truncated toward zero
// and zero on a miss. Parallel and collinear pairs never hit; touching at an
// end does. The unit takes one request per cycle, back to back, and keeps
// that rate as long as results are taken. A request passes through the
// front end stages (differences, cross products, sign test), the four-entry
// queue and the back end stages: point numerators, their magnitudes, the
// divider, which retires one quotient bit per stage, and the output
// register. When the result side stalls, the back end holds and the queue
// absorbs the front end's requests in flight before input requests are
// refused.
module segment_intersection_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: seg1_start_x, seg1_start_y, seg1_end_x, seg1_end_y,
    // seg2_start_x, seg2_start_y, seg2_end_x, seg2_end_y.
    input  logic [sint_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0 up: hit, cross_x, cross_y, then zero fill.
    output logic [sint_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import sint_pkg::*;

    logic      fe_valid, fe_ready, be_valid, be_ready;
    sint_job_t fe_job, be_job;
    logic      hit;
    logic signed [COORD_WIDTH-1:0] cross_x, cross_y;

    // The front end classifies each request and computes its exact numerators.
    sint_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata[IN_BITS-1:0]),
        .job_valid (fe_valid),
        .job_ready (fe_ready),
        .job       (fe_job)
    );

    // The queue lets the two halves stall independently.
    sint_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fe_valid),
        .wr_ready (fe_ready),
        .wr_job   (fe_job),
        .rd_valid (be_valid),
        .rd_ready (be_ready),
        .rd_job   (be_job)
    );

    // The back end builds the crossing point and divides by den.
    sint_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (be_valid),
        .job_ready (be_ready),
        .job       (be_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_hit   (hit),
        .out_x     (cross_x),
        .out_y     (cross_y)
    );

    assign m_tdata = OUT_TDATA_W'({cross_y, cross_x, hit});

endmodule

// ===== hw/rtl/sint_front.sv =====
// Front end of the segment intersection unit: differences, cross products
// and the hit decision in three stages. Depends on sint_pkg.
module sint_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sint_pkg::IN_BITS-1:0]     in_data,
    output logic                             job_valid,
    input  logic                             job_ready,
    output sint_pkg::sint_job_t              job
);
    import sint_pkg::*;

    logic signed [COORD_WIDTH-1:0] c [8];
    logic en;

    logic                          v1_reg, v2_reg, v3_reg;
    logic signed [DIFF_W-1:0]      d1x_reg, d1y_reg, d2x_reg, d2y_reg, wx_reg, wy_reg;
    logic signed [COORD_WIDTH-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic signed [DIFF_W-1:0]      d1x2_reg, d1y2_reg;
    logic signed [PROD_W-1:0]      pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    sint_job_t                     job_reg;

    logic signed [NUM_W-1:0]       den_raw, sn_raw, tn_raw, den_n, sn_n, tn_n;
    logic signed [NUM_W:0]         dms, dmt;
    sint_job_t                     job_next;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            c[k] = in_data[k*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    assign en       = !v3_reg || job_ready;
    assign in_ready = en;

    always_comb begin
        den_raw = NUM_W'(pa_reg) - NUM_W'(pb_reg);
        sn_raw  = NUM_W'(pc_reg) - NUM_W'(pd_reg);
        tn_raw  = NUM_W'(pe_reg) - NUM_W'(pf_reg);
        if (den_raw[NUM_W-1]) begin
            den_n = -den_raw;
            sn_n  = -sn_raw;
            tn_n  = -tn_raw;
        end else begin
            den_n = den_raw;
            sn_n  = sn_raw;
            tn_n  = tn_raw;
        end
        dms = (NUM_W+1)'(den_n) - (NUM_W+1)'(sn_n);
        dmt = (NUM_W+1)'(den_n) - (NUM_W+1)'(tn_n);
        job_next.hit = (den_n != '0) && !sn_n[NUM_W-1] && !tn_n[NUM_W-1]
                       && !dms[NUM_W] && !dmt[NUM_W];
        job_next.den = den_n;
        job_next.tn  = tn_n;
        job_next.ax  = ax2_reg;
        job_next.ay  = ay2_reg;
        job_next.d1x = d1x2_reg;
        job_next.d1y = d1y2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (en) begin
            d1x_reg  <= DIFF_W'(c[2]) - DIFF_W'(c[0]);
            d1y_reg  <= DIFF_W'(c[3]) - DIFF_W'(c[1]);
            d2x_reg  <= DIFF_W'(c[6]) - DIFF_W'(c[4]);
            d2y_reg  <= DIFF_W'(c[7]) - DIFF_W'(c[5]);
            wx_reg   <= DIFF_W'(c[0]) - DIFF_W'(c[4]);
            wy_reg   <= DIFF_W'(c[1]) - DIFF_W'(c[5]);
            ax1_reg  <= c[0];
            ay1_reg  <= c[1];
            pa_reg   <= d1x_reg * d2y_reg;
            pb_reg   <= d2x_reg * d1y_reg;
            pc_reg   <= d1x_reg * wy_reg;
            pd_reg   <= d1y_reg * wx_reg;
            pe_reg   <= d2x_reg * wy_reg;
            pf_reg   <= d2y_reg * wx_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            job_reg  <= job_next;
        end
    end

    assign job_valid = v3_reg;
    assign job       = job_reg;

endmodule

// ===== hw/rtl/sint_fifo.sv =====
// Short queue of classified requests between the front and back ends.
// Depends on sint_pkg.
module sint_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  sint_pkg::sint_job_t wr_job,
    output logic                rd_valid,
    input  logic                rd_ready,
    output sint_pkg::sint_job_t rd_job
);
    import sint_pkg::*;

    sint_job_t          mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               push, pop;

    assign wr_ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
        end
        if (push) mem[wr_ptr_reg] <= wr_job;
    end

endmodule

// ===== hw/rtl/sint_back.sv =====
// Back end of the segment intersection unit: crossing point numerators and a
// pipelined restoring divider, one quotient bit per stage. Depends on sint_pkg.
module sint_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  sint_pkg::sint_job_t                 job,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_hit,
    output logic signed [sint_pkg::COORD_WIDTH-1:0] out_x,
    output logic signed [sint_pkg::COORD_WIDTH-1:0] out_y
);
    import sint_pkg::*;

    logic en;

    logic                    va_reg, hita_reg;
    logic signed [NUM_W-1:0] dena_reg;
    logic signed [NX_W-1:0]  mx_reg, mtx_reg, my_reg, mty_reg;
    logic signed [NX_W-1:0]  nx, ny;

    logic [QUO_W:0]          sv_reg;
    logic                    shit_reg [QUO_W+1];
    logic                    snx_reg  [QUO_W+1];
    logic                    sny_reg  [QUO_W+1];
    logic [NX_W-1:0]         sden_reg [QUO_W+1];
    logic [NX_W-1:0]         srx_reg  [QUO_W+1];
    logic [NX_W-1:0]         sry_reg  [QUO_W+1];
    logic [QUO_W-1:0]        sqx_reg  [QUO_W+1];
    logic [QUO_W-1:0]        sqy_reg  [QUO_W+1];

    logic [NX_W-1:0]         rx_next [QUO_W];
    logic [NX_W-1:0]         ry_next [QUO_W];
    logic [QUO_W-1:0]        qx_next [QUO_W];
    logic [QUO_W-1:0]        qy_next [QUO_W];

    logic                    ov_reg, ohit_reg;
    logic signed [COORD_WIDTH-1:0] ox_reg, oy_reg;
    logic [QUO_W-1:0]        qx_s, qy_s;

    assign en        = !ov_reg || out_ready;
    assign job_ready = en;

    assign nx = mx_reg + mtx_reg;
    assign ny = my_reg + mty_reg;

    always_comb begin
        for (int k = 0; k < QUO_W; k++) begin
            logic [NX_W-1:0] dsh;
            dsh = sden_reg[k] << (QUO_W - 1 - k);
            if (srx_reg[k] >= dsh) begin
                rx_next[k] = srx_reg[k] - dsh;
                qx_next[k] = {sqx_reg[k][QUO_W-2:0], 1'b1};
            end else begin
                rx_next[k] = srx_reg[k];
                qx_next[k] = {sqx_reg[k][QUO_W-2:0], 1'b0};
            end
            if (sry_reg[k] >= dsh) begin
                ry_next[k] = sry_reg[k] - dsh;
                qy_next[k] = {sqy_reg[k][QUO_W-2:0], 1'b1};
            end else begin
                ry_next[k] = sry_reg[k];
                qy_next[k] = {sqy_reg[k][QUO_W-2:0], 1'b0};
            end
        end
        qx_s = snx_reg[QUO_W] ? -sqx_reg[QUO_W] : sqx_reg[QUO_W];
        qy_s = sny_reg[QUO_W] ? -sqy_reg[QUO_W] : sqy_reg[QUO_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            sv_reg <= '0;
            ov_reg <= 1'b0;
        end else if (en) begin
            va_reg <= job_valid;
            sv_reg <= {sv_reg[QUO_W-1:0], va_reg};
            ov_reg <= sv_reg[QUO_W];
        end
        if (en) begin
            hita_reg <= job.hit;
            dena_reg <= job.den;
            mx_reg   <= job.ax * job.den;
            my_reg   <= job.ay * job.den;
            mtx_reg  <= job.tn * job.d1x;
            mty_reg  <= job.tn * job.d1y;

            shit_reg[0] <= hita_reg;
            snx_reg[0]  <= nx[NX_W-1];
            sny_reg[0]  <= ny[NX_W-1];
            sden_reg[0] <= NX_W'(dena_reg);
            srx_reg[0]  <= nx[NX_W-1] ? NX_W'(-nx) : NX_W'(nx);
            sry_reg[0]  <= ny[NX_W-1] ? NX_W'(-ny) : NX_W'(ny);
            sqx_reg[0]  <= '0;
            sqy_reg[0]  <= '0;
            for (int k = 0; k < QUO_W; k++) begin
                shit_reg[k+1] <= shit_reg[k];
                snx_reg[k+1]  <= snx_reg[k];
                sny_reg[k+1]  <= sny_reg[k];
                sden_reg[k+1] <= sden_reg[k];
                srx_reg[k+1]  <= rx_next[k];
                sry_reg[k+1]  <= ry_next[k];
                sqx_reg[k+1]  <= qx_next[k];
                sqy_reg[k+1]  <= qy_next[k];
            end

            ohit_reg <= shit_reg[QUO_W];
            ox_reg   <= shit_reg[QUO_W] ? COORD_WIDTH'(qx_s) : '0;
            oy_reg   <= shit_reg[QUO_W] ? COORD_WIDTH'(qy_s) : '0;
        end
    end

    assign out_valid = ov_reg;
    assign out_hit   = ohit_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;

endmodule

// ===== verif/tb_top.sv =====
// Testbench for segment_intersection_unit: random and directed segment pairs
// are checked against an integer predictor of the hit flag and crossing point.
// Depends on sint_pkg and the RTL of the unit.
`timescale 1ns / 1ps

class seg_scoreboard;
    logic [32:0] pending_results[$];
    int errors;
    int checked;
    int hits;

    // Exact integer prediction: parametric test by sign, point by truncating division.
    function logic [32:0] predict_crossing(logic signed [15:0] c[8]);
        longint d1x, d1y, d2x, d2y, wx, wy, den, sn, tn, nx, ny, px, py;
        logic [15:0] ox, oy;
        d1x = longint'(c[2]) - longint'(c[0]);
        d1y = longint'(c[3]) - longint'(c[1]);
        d2x = longint'(c[6]) - longint'(c[4]);
        d2y = longint'(c[7]) - longint'(c[5]);
        wx = longint'(c[0]) - longint'(c[4]);
        wy = longint'(c[1]) - longint'(c[5]);
        den = d1x * d2y - d2x * d1y;
        sn = d1x * wy - d1y * wx;
        tn = d2x * wy - d2y * wx;
        if (den == 0) return 33'd0;
        if (den < 0) begin
            den = -den;
            sn = -sn;
            tn = -tn;
        end
        if (sn < 0 || sn > den || tn < 0 || tn > den) return 33'd0;
        // The numerators fit in 64 bits: |a*den| < 2^50, |tn*d1| < 2^50.
        nx = longint'(c[0]) * den + tn * d1x;
        ny = longint'(c[1]) * den + tn * d1y;
        px = nx / den;
        py = ny / den;
        ox = px[15:0];
        oy = py[15:0];
        return {oy, ox, 1'b1};
    endfunction

    function void note_request(logic [127:0] data);
        logic signed [15:0] c[8];
        for (int i = 0; i < 8; i++) c[i] = data[16*i +: 16];
        pending_results.push_back(predict_crossing(c));
    endfunction

    function void check_result(logic [39:0] data);
        logic [32:0] exp_r;
        if (pending_results.size() == 0) begin
            $error("result with no request outstanding: %h", data);
            errors++;
            return;
        end
        exp_r = pending_results.pop_front();
        checked++;
        if (exp_r[0]) hits++;
        if (data[0] !== exp_r[0]) begin
            $error("hit: expected %0d, actual %0d", exp_r[0], data[0]);
            errors++;
        end
        if (data[16:1] !== exp_r[16:1]) begin
            $error("cross_x: expected %0d, actual %0d",
                   $signed(exp_r[16:1]), $signed(data[16:1]));
            errors++;
        end
        if (data[32:17] !== exp_r[32:17]) begin
            $error("cross_y: expected %0d, actual %0d",
                   $signed(exp_r[32:17]), $signed(data[32:17]));
            errors++;
        end
        if (data[39:33] !== 7'd0) begin
            $error("fill: expected 0, actual %h", data[39:33]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sint_pkg::IN_TDATA_W-1:0] s_tdata = '0;   // seg1 sx,sy,ex,ey, seg2 sx,sy,ex,ey
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sint_pkg::OUT_TDATA_W-1:0] m_tdata;       // hit, cross_x, cross_y, zero fill

    seg_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    longint cycle_count = 0;
    int sent = 0;

    segment_intersection_unit u_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sampling at the rising edge: every accepted request and result is
    // handed to the scoreboard there.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (cycle_count > 400000) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Receiver stalls change at the falling edge.
    always @(negedge aclk) begin
        if (aresetn) m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one request and holds it until it is taken; idles before it at random.
    // The valid stays high after acceptance until the next request or an idle
    // cycle replaces it.
    task automatic send_segments(logic signed [15:0] c[8]);
        logic [127:0] d;
        for (int i = 0; i < 8; i++) d[16*i +: 16] = c[i];
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic send_coords(int a, int b, int c2, int d, int e, int f, int g, int h);
        logic signed [15:0] c[8];
        c = '{a[15:0], b[15:0], c2[15:0], d[15:0], e[15:0], f[15:0], g[15:0], h[15:0]};
        send_segments(c);
    endtask

    function automatic logic signed [15:0] rand_coord(int span);
        if (span >= 32768) return 16'($urandom);
        return 16'($signed($urandom_range(2 * span)) - span);
    endfunction

    // Mostly crossing pairs: segment two is built through a point on segment one.
    task automatic send_random();
        logic signed [15:0] c[8];
        int span, mode;
        mode = $urandom_range(9);
        span = ($urandom_range(3) == 0) ? 32768 : (1 << $urandom_range(2, 14));
        for (int i = 0; i < 8; i++) c[i] = rand_coord(span);
        if (mode < 5) begin
            // Mirror segment two about the midpoint of segment one.
            int mx, my;
            mx = (int'(c[0]) + int'(c[2])) / 2;
            my = (int'(c[1]) + int'(c[3])) / 2;
            c[6] = 16'(2 * mx - int'(c[4]));
            c[7] = 16'(2 * my - int'(c[5]));
        end else if (mode == 5) begin
            c[4] = c[0];
            c[5] = c[1];   // touching at an end
        end else if (mode == 6) begin
            c[6] = c[4] + (c[2] - c[0]);
            c[7] = c[5] + (c[3] - c[1]);   // parallel
        end
        send_segments(c);
    endtask

    // Drops the input valid and waits until every expected result has come.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    initial begin
        send_idle_pct = 12;
        recv_idle_pct = 69;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        // Directed cases: plain crossing, endpoint touch, parallel, collinear overlap,
        // zero length, miss, and coordinate extremes.
        send_coords(0, 0, 10, 10, 0, 10, 10, 0);
        send_coords(0, 0, 10, 0, 10, 0, 10, 10);
        send_coords(0, 0, 10, 0, 0, 5, 10, 5);
        send_coords(0, 0, 10, 0, 5, 0, 15, 0);
        send_coords(3, 3, 3, 3, 0, 0, 10, 10);
        send_coords(0, 0, 1, 1, 5, 0, 6, -3);
        send_coords(-7, 1, 8, 4, 3, -9, -2, 11);
        send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        send_coords(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        send_coords(-32768, -32768, 32767, -32767, 32767, -32768, -32768, -32767);
        send_coords(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768);
        send_coords(-1, -1, -1, -1, -1, -1, -1, -1);
        send_coords(0, 0, 0, 0, 0, 0, 0, 0);
        send_coords(-32768, 32767, -32768, 32767, 1, 2, 3, 4);
        send_coords(0, 0, 3, 1, 1, 0, 2, 1);
        for (int phase = 0; phase < 3; phase++) begin
            for (int n = 0; n < 310; n++) begin
                send_random();
                if (phase == 0 && n == 150) drain_results();
            end
            drain_results();
            send_idle_pct = (phase == 0) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 12 : 0;
        end
        drain_results();
        repeat (40) @(negedge aclk);
        $display("Sent %0d segment pairs and checked %0d results, %0d of them hits,",
                 sent, sb.checked, sb.hits);
        $display("under sender and receiver stalls and back-to-back traffic.");
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
